@@ design/tmk_pkg.sv @@
`default_nettype none
package tmk_pkg;

  localparam int SECRET_BYTES_DEF = 32;
  localparam int SECRET_BYTES_MAX = 55;

  localparam logic [14:0] DIVISOR_RST = 15'd60;
  localparam logic [7:0]  ROUNDS_RST  = 8'd1;
  localparam logic [5:0]  SECLEN_RST  = 6'd16;

  typedef enum logic [2:0] {
    REG_DIVISOR = 3'd0,
    REG_ROUNDS  = 3'd1,
    REG_OFFSET  = 3'd2,
    REG_SECLEN  = 3'd3,
    REG_SEC0    = 3'd4,
    REG_SEC1    = 3'd5,
    REG_SEC2    = 3'd6,
    REG_SEC3    = 3'd7
  } reg_idx_t;

  // Handshake between the sequencer and the MD5 block unit.
  typedef struct packed {
    logic       start;
    logic       first;
  } md5_ctl_t;

  typedef struct packed {
    logic       busy;
    logic       done;
  } md5_sts_t;

  function automatic logic [31:0] md5_k(input logic [5:0] i);
    logic [31:0] k;
    case (i)
      6'd0: k = 32'hd76aa478; 6'd1: k = 32'he8c7b756; 6'd2: k = 32'h242070db;
      6'd3: k = 32'hc1bdceee; 6'd4: k = 32'hf57c0faf; 6'd5: k = 32'h4787c62a;
      6'd6: k = 32'ha8304613; 6'd7: k = 32'hfd469501; 6'd8: k = 32'h698098d8;
      6'd9: k = 32'h8b44f7af; 6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
      6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
      6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
      6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
      6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
      6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
      6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
      6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
      6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
      default: k = 32'heb86d391;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] md5_r(input logic [3:0] i);
    logic [4:0] r;
    case (i)
      4'd0: r = 5'd7;   4'd1: r = 5'd12;  4'd2: r = 5'd17;  4'd3: r = 5'd22;
      4'd4: r = 5'd5;   4'd5: r = 5'd9;   4'd6: r = 5'd14;  4'd7: r = 5'd20;
      4'd8: r = 5'd4;   4'd9: r = 5'd11;  4'd10: r = 5'd16; 4'd11: r = 5'd23;
      4'd12: r = 5'd6;  4'd13: r = 5'd10; 4'd14: r = 5'd15; default: r = 5'd21;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

@@ design/tmk_stream_if.sv @@
`default_nettype none
interface tmk_stream_if #(
  parameter int W = 8
);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ design/time_based_md5_key_derivation_unit.sv @@
`default_nettype none
// Flow: a restoring divide, then 3 + 2*flush_rounds MD5 blocks with one
// mixing step per round between them. Throughput: one word at a time; the
// next word is taken in the cycle after the result is loaded, even while
// that result waits. Reset (synchronous, rst_n low): registers take their
// documented values, the sequencer goes idle.
module time_based_md5_key_derivation_unit #(
  parameter int SECRET_BYTES = tmk_pkg::SECRET_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  tmk_stream_if.sink       in_ch,
  tmk_stream_if.source     out_ch,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);
  // Hashed secret length is capped at SECRET_BYTES; bytes past the 32 stored
  // ones read as zero.
  localparam logic [5:0] SEC_CAP = 6'(SECRET_BYTES);

  // The sequencer walks through these jobs; every MD5 message here fits in
  // a single compression on the shared step unit.
  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_TH, S_KH, S_C1,
    S_R1, S_MIX, S_R2, S_OUT
  } state_t;

  state_t         state_r;
  logic [14:0]    div_r;
  logic [7:0]     rounds_r;
  logic [31:0]    offset_r;
  logic [5:0]     seclen_r;
  logic [255:0]   secret_r;
  logic [31:0]    adj_r, quo_r, rem_r;
  logic [31:0]    slot;
  logic [7:0]     shift_r, round_r;
  logic [5:0]     cnt_r;
  logic [127:0]   t_r, k_r, s_r;
  logic [23:0]    w_r;
  logic [511:0]   blk_r;
  logic           md_wait_r;
  logic [159:0]   out_data_r;
  logic           out_valid_r;
  logic           out_load;

  tmk_pkg::md5_ctl_t ctl;
  tmk_pkg::md5_sts_t sts;
  logic [127:0]      hash;

  tmk_md5_block u_md5 (
    .clk(clk), .rst_n(rst_n), .ctl(ctl), .blk(blk_r), .sts(sts), .hash(hash)
  );

  // Byte j of a 16-byte MD5 digest sits at bits [8j+7:8j] (little-endian).
  // Secret byte i is bits [255-8i -: 8] of the register image.
  function automatic logic [7:0] sec_byte(input logic [255:0] s, input int i);
    return s[255 - 8*i -: 8];
  endfunction

  // Secret message block: bytes below len, then 0x80, then bit length.
  logic [511:0]  kmsg;
  logic [5:0]    klen;
  always_comb begin
    klen = (seclen_r < SEC_CAP) ? seclen_r : SEC_CAP;
    kmsg = '0;
    for (int i = 0; i < 64; i++) begin
      if (i < 32 && 6'(i) < klen) kmsg[8*i +: 8] = sec_byte(secret_r, i);
      else if (6'(i) == klen) kmsg[8*i +: 8] = 8'h80;
    end
    kmsg[448 +: 16] = {7'd0, klen, 3'd0};
  end

  // Weights and convolution over the reversed round digest.
  logic [127:0] rev;
  logic [7:0]   wv [3];
  logic [127:0] mixed;
  always_comb begin
    for (int i = 0; i < 16; i++) rev[8*i +: 8] = hash[8*(15-i) +: 8];
    for (int j = 0; j < 3; j++) begin
      logic [8:0] t;
      logic [4:0] lo;
      logic [4:0] qt;
      lo = rev[8*j +: 5];
      // The weight divisor is 1 to 4; three is a multiply by 11 and a
      // shift by 5, exact for the 5-bit range.
      case (div_r[1:0])
        2'd0: qt = lo;
        2'd1: qt = {1'b0, lo[4:1]};
        2'd2: qt = 5'((10'(lo) * 10'd11) >> 5);
        default: qt = {2'b00, lo[4:2]};
      endcase
      t  = {1'b0, rev[8*j +: 8]} + {4'd0, qt};
      if (t >= 9'd255) t = t - 9'd255;
      wv[j] = 8'(t + 9'd1);
    end
    mixed = rev;
    for (int j = 3; j < 14; j++)
      mixed[8*j +: 8] = 8'(rev[8*j +: 8] * wv[0]) + 8'(rev[8*(j+1) +: 8] * wv[1])
                      + 8'(rev[8*(j+2) +: 8] * wv[2]);
  end

  logic [32:0] rem_try;
  assign rem_try = {rem_r, quo_r[31]} - {18'd0, div_r};

  // Slot is the quotient plus the sign-extended shift, wrapping at 32 bits.
  assign slot = ((div_r == '0) ? 32'hFFFFFFFF : quo_r) + {{24{shift_r[7]}}, shift_r};

  // A finished key moves to the output register once that register is free
  // or being emptied in the same cycle.
  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_ch.ready);

  always_comb begin
    ctl.start = 1'b0;
    ctl.first = 1'b0;
    case (state_r)
      S_TH, S_KH, S_C1, S_R1, S_R2: begin
        ctl.start = !md_wait_r; ctl.first = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      div_r       <= tmk_pkg::DIVISOR_RST;
      rounds_r    <= tmk_pkg::ROUNDS_RST;
      offset_r    <= '0;
      seclen_r    <= tmk_pkg::SECLEN_RST;
      secret_r    <= '0;
      md_wait_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          tmk_pkg::REG_DIVISOR: div_r    <= cfg_data[14:0];
          tmk_pkg::REG_ROUNDS:  rounds_r <= cfg_data[7:0];
          tmk_pkg::REG_OFFSET:  offset_r <= cfg_data[31:0];
          tmk_pkg::REG_SECLEN:  seclen_r <= cfg_data[5:0];
          tmk_pkg::REG_SEC0:    secret_r[255:192] <= cfg_data;
          tmk_pkg::REG_SEC1:    secret_r[191:128] <= cfg_data;
          tmk_pkg::REG_SEC2:    secret_r[127:64]  <= cfg_data;
          tmk_pkg::REG_SEC3:    secret_r[63:0]    <= cfg_data;
          default: ;
        endcase
      end
      if (out_load) out_valid_r <= 1'b1;
      else if (out_valid_r && out_ch.ready) out_valid_r <= 1'b0;
      if (ctl.start) md_wait_r <= 1'b1;
      else if (sts.done) md_wait_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            adj_r   <= in_ch.data[39:8] + offset_r;
            quo_r   <= in_ch.data[39:8] + offset_r;
            shift_r <= in_ch.data[7:0];
            rem_r   <= '0;
            cnt_r   <= '0;
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          // Restoring divide, one quotient bit per cycle.
          if (!rem_try[32]) rem_r <= rem_try[31:0];
          else rem_r <= {rem_r[30:0], quo_r[31]};
          quo_r <= {quo_r[30:0], ~rem_try[32]};
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == 6'd31) begin
            state_r <= S_TH;
            blk_r   <= '0;
          end
        end
        S_TH: begin
          if (!md_wait_r) blk_r <= {64'd32, 384'd0, 32'h80, slot};
          if (sts.done) begin
            t_r <= hash; state_r <= S_KH; blk_r <= kmsg;
          end
        end
        S_KH: if (sts.done) begin
          k_r <= hash; state_r <= S_C1;
          blk_r <= '0;
        end
        S_C1: begin
          if (!md_wait_r) blk_r <= {64'd256, 184'd0, 8'h80, k_r, t_r};
          if (sts.done) begin
            s_r <= hash; round_r <= '0;
            state_r <= (rounds_r == '0) ? S_OUT : S_R1;
          end
        end
        S_R1: begin
          if (!md_wait_r) blk_r <= {64'd128, 312'd0, 8'h80, s_r};
          if (sts.done) state_r <= S_MIX;
        end
        S_MIX: begin
          w_r <= {wv[2], wv[1], wv[0]};
          s_r <= mixed;
          state_r <= S_R2;
        end
        S_R2: begin
          // S, then the three weights, then the secret digest: 35 bytes.
          if (!md_wait_r) blk_r <= {64'd280, 160'd0, 8'h80, k_r, w_r, s_r};
          if (sts.done) begin
            s_r <= hash; round_r <= round_r + 8'd1;
            state_r <= (round_r + 8'd1 == rounds_r) ? S_OUT : S_R1;
          end
        end
        S_OUT: begin
          if (out_load) begin
            for (int i = 0; i < 8; i++) begin
              out_data_r[96 + 8*(7-i) +: 8] <= s_r[8*i +: 8];
              out_data_r[32 + 8*(7-i) +: 8] <= s_r[8*(8+i) +: 8];
            end
            out_data_r[31:0] <= adj_r;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ch.ready  = (state_r == S_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  a_busy_no_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_ch.ready) else $error("ready while busy");
  a_start_div: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> state_r == S_DIV) else $error("no start");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |=> out_valid_r) else $error("result dropped");
endmodule
`default_nettype wire

@@ design/tmk_md5_block.sv @@
`default_nettype none
// One MD5 compression, one of the 64 steps per cycle.
module tmk_md5_block (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire tmk_pkg::md5_ctl_t ctl,
  input  wire logic [511:0]   blk,
  output tmk_pkg::md5_sts_t   sts,
  output logic [127:0]        hash
);
  logic [31:0] a_r, b_r, c_r, d_r, a_nxt, b_nxt, c_nxt, d_nxt;
  logic [31:0] h0_r, h1_r, h2_r, h3_r;
  logic [5:0]  step_r;
  logic        busy_r, done_r;
  logic [31:0] f, m, sum, rot, ha, hb, hc, hd;
  logic [3:0]  g;
  logic [4:0]  sh;

  always_comb begin
    case (step_r[5:4])
      2'd0: begin f = (b_r & c_r) | (~b_r & d_r); g = step_r[3:0]; end
      2'd1: begin f = (d_r & b_r) | (~d_r & c_r); g = 4'(5 * step_r + 1); end
      2'd2: begin f = b_r ^ c_r ^ d_r;            g = 4'(3 * step_r + 5); end
      default: begin f = c_r ^ (b_r | ~d_r);      g = 4'(7 * step_r); end
    endcase
    m   = blk[32*g +: 32];
    sh  = tmk_pkg::md5_r({step_r[5:4], step_r[1:0]});
    sum = a_r + f + tmk_pkg::md5_k(step_r) + m;
    rot = (sum << sh) | (sum >> (6'd32 - {1'b0, sh}));
    a_nxt = d_r;
    d_nxt = c_r;
    c_nxt = b_r;
    b_nxt = b_r + rot;
  end

  always_comb begin
    if (ctl.first) begin
      ha = 32'h67452301; hb = 32'hefcdab89; hc = 32'h98badcfe; hd = 32'h10325476;
    end else begin
      ha = h0_r; hb = h1_r; hc = h2_r; hd = h3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start && !busy_r) begin
        busy_r <= 1'b1;
        step_r <= '0;
        h0_r <= ha; h1_r <= hb; h2_r <= hc; h3_r <= hd;
        a_r  <= ha; b_r  <= hb; c_r  <= hc; d_r  <= hd;
      end else if (busy_r) begin
        a_r <= a_nxt; b_r <= b_nxt; c_r <= c_nxt; d_r <= d_nxt;
        step_r <= step_r + 6'd1;
        if (step_r == 6'd63) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
          h0_r <= h0_r + a_nxt; h1_r <= h1_r + b_nxt;
          h2_r <= h2_r + c_nxt; h3_r <= h3_r + d_nxt;
        end
      end
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign hash = {h3_r, h2_r, h1_r, h0_r};

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r) else $error("done while busy");
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.start && !busy_r) |=> busy_r) else $error("start lost");
  a_done_step: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(done_r) |-> $past(step_r) == 6'd63) else $error("early done");
endmodule
`default_nettype wire
